### hw/rtl/rcm_pkg.sv
package rcm_pkg;

   localparam int ANGLE_W     = 12;
   localparam int QUARTER     = 1024;
   localparam int ROM_W       = 15;
   localparam int TRIG_W      = 16;
   localparam int MAP_CELLS   = 16;
   localparam int COLUMN_W    = 9;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int RSP_DATA_W  = 40;
   localparam int OUT_W       = 8;

   // one cell spans 10 steps of 0.1 cell at Q14 (16384), i.e. 256 (Q8) * 640 = 163840 = 5 << 15
   localparam int CELL_SPAN   = 163840;
   localparam int CELL_SHIFT  = 15;
   localparam int DIV5_MUL    = 205;
   localparam int DIV5_SHIFT  = 10;
   // ceiling = (H*n - ROW_SCALE*H) / (2n)
   localparam int ROW_SCALE   = 20;

   localparam logic [CSR_INDEX_W-1:0] REG_MAP_0     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_1     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_2     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_3     = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PLAYER_X  = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PLAYER_Y  = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PLAYER_A  = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FOV       = 8'd7;

   typedef logic [ROM_W-1:0] sin_rom_type [0:QUARTER];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG_MUL,
      ST_ANG_GO,
      ST_ANG_WAIT,
      ST_SIN,
      ST_COS,
      ST_SETUP,
      ST_MARCH,
      ST_ROW_MUL,
      ST_ROW_GO,
      ST_ROW_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic angle_mul;
      logic div_start;
      logic angle_div;
      logic angle_load;
      logic sin_rd;
      logic cos_rd;
      logic setup;
      logic march_step;
      logic row_mul;
      logic ceil_load;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic march_end;
      logic rsp_hold;
   } sts_type;

   typedef struct packed {
      logic [4*CSR_DATA_W-1:0] map;
      logic [ANGLE_W-1:0]      player_x;
      logic [ANGLE_W-1:0]      player_y;
      logic [ANGLE_W-1:0]      player_angle;
      logic [ANGLE_W-1:0]      fov;
   } cfg_type;

   // nonnegative quotient by shift and subtract
   function automatic longint div_pos(input longint n, input longint d);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r <<< 1) | ((n >>> b) & 64'sd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'sd1 <<< b);
         end
      end
      return q;
   endfunction

   // Q1.14 sine of a quarter-turn index, Taylor series in Q30
   function automatic logic [ROM_W-1:0] quarter_sin(input int q);
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint r;
      x    = longint'(q) * 64'sd1647099;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 6; k++) begin
         term = (term * x2) >>> 30;
         term = div_pos(term, longint'((2 * k) * (2 * k + 1)));
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 32768) >>> 16;
      if (r > 16384) begin
         r = 16384;
      end
      return ROM_W'(r);
   endfunction

   function automatic sin_rom_type build_sin_rom();
      sin_rom_type t;
      for (int i = 0; i <= QUARTER; i++) begin
         t[i] = quarter_sin(i);
      end
      return t;
   endfunction

   localparam sin_rom_type SIN_ROM = build_sin_rom();

endpackage

### hw/rtl/rcm_div.sv
module rcm_div #(
   parameter int DIVD_W = 21,
   parameter int DIVS_W = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [DIVS_W:0]   rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DIVS_W-1:0], quo_ff[DIVD_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/rcm_dp.sv
module rcm_dp #(
   parameter int SCREEN_WIDTH  = 360,
   parameter int SCREEN_HEIGHT = 228,
   parameter int MAX_STEPS     = 160
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rcm_pkg::cmd_type                cmd,
   output rcm_pkg::sts_type                sts,
   input  rcm_pkg::cfg_type                cfg,
   input  logic [rcm_pkg::COLUMN_W-1:0]    column,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [rcm_pkg::RSP_DATA_W-1:0]  rsp_data
);

   localparam int N_W      = $clog2(MAX_STEPS + 1);
   localparam int H_W      = $clog2(SCREEN_HEIGHT + 1);
   localparam int W_W      = $clog2(SCREEN_WIDTH + 1);
   localparam int PROD_W   = rcm_pkg::COLUMN_W + rcm_pkg::ANGLE_W;
   localparam int NUM_W    = H_W + N_W;
   localparam int DIVD_W   = (PROD_W > NUM_W) ? PROD_W : NUM_W;
   localparam int DIVS_W   = (W_W > N_W + 1) ? W_W : N_W + 1;
   localparam int TRAVEL_W = rcm_pkg::ROM_W + N_W;
   localparam int BASE_W   = rcm_pkg::ANGLE_W + 10;
   localparam int AX_W     = ((TRAVEL_W > BASE_W) ? TRAVEL_W : BASE_W) + 2;
   localparam int IDX_W    = $clog2(rcm_pkg::QUARTER + 1);
   localparam int Q_W      = 7;
   localparam int QM_W     = 15;
   // reciprocal of the screen width, exact for any PROD_W-bit product
   localparam int RCP_SH   = PROD_W + $clog2(SCREEN_WIDTH);
   localparam int RCP_W    = PROD_W + 1;
   localparam int SP_W     = PROD_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP_M =
      RCP_W'(((64'd1 << RCP_SH) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

   logic [rcm_pkg::COLUMN_W-1:0]  col_ff;
   logic [DIVD_W-1:0]             prod_ff;
   logic [rcm_pkg::ANGLE_W-1:0]   span_ff;
   logic [rcm_pkg::ANGLE_W-1:0]   angle_ff;
   logic [rcm_pkg::ROM_W-1:0]     rom_ff;
   logic                          neg_ff;
   logic signed [rcm_pkg::TRIG_W-1:0] s_ff, c_ff;
   logic signed [AX_W-1:0]        ax_ff, ay_ff;
   logic [N_W-1:0]                n_ff;
   logic                          hit_ff;
   logic [H_W-1:0]                ceil_ff;
   logic                          rsp_valid_ff;
   logic [rcm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [DIVD_W-1:0]             div_dividend;
   logic [DIVS_W-1:0]             div_divisor;
   logic                          div_done;
   logic [DIVD_W-1:0]             quot;
   logic [SP_W-1:0]               span_prod;
   logic [rcm_pkg::ANGLE_W-1:0]   cos_angle;
   logic signed [rcm_pkg::TRIG_W-1:0] trig_val;
   logic signed [AX_W-1:0]        base_x, base_y;
   logic [4:0]                    cell_x, cell_y;
   logic                          wall;
   logic                          at_max;
   logic [DIVD_W-1:0]             row_num;
   logic [H_W-1:0]                floor_val;

   function automatic logic [IDX_W-1:0] rom_index(input logic [rcm_pkg::ANGLE_W-1:0] a);
      logic [IDX_W-1:0] idx;
      if (a[10]) begin
         idx = IDX_W'(rcm_pkg::QUARTER) - IDX_W'(a[9:0]);
      end else begin
         idx = IDX_W'(a[9:0]);
      end
      return idx;
   endfunction

   // bit 4 flags a position off the map; truncation is toward zero
   function automatic logic [4:0] cell_of(input logic signed [AX_W-1:0] v);
      logic [Q_W-1:0]  q;
      logic [QM_W-1:0] qm;
      logic [4:0]      r;
      q  = Q_W'(v >>> rcm_pkg::CELL_SHIFT);
      qm = QM_W'(q) * QM_W'(rcm_pkg::DIV5_MUL);
      if (v <= -rcm_pkg::CELL_SPAN || v >= rcm_pkg::MAP_CELLS * rcm_pkg::CELL_SPAN) begin
         r = 5'b10000;
      end else if (v < 0) begin
         r = 5'b00000;
      end else begin
         r = {1'b0, 4'(qm >> rcm_pkg::DIV5_SHIFT)};
      end
      return r;
   endfunction

   rcm_div #(
      .DIVD_W (DIVD_W),
      .DIVS_W (DIVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      div_divisor  = DIVS_W'({n_ff, 1'b0});
      div_dividend = prod_ff;
      span_prod    = SP_W'(prod_ff[PROD_W-1:0]) * SP_W'(RCP_M);
      cos_angle    = angle_ff + rcm_pkg::ANGLE_W'(rcm_pkg::QUARTER);
      if (neg_ff) begin
         trig_val = -$signed({1'b0, rom_ff});
      end else begin
         trig_val = $signed({1'b0, rom_ff});
      end
      // Q8 position times 640 brings it to the Q14 * 10 step scale
      base_x = $signed(AX_W'({cfg.player_x, 9'b0}) + AX_W'({cfg.player_x, 7'b0}));
      base_y = $signed(AX_W'({cfg.player_y, 9'b0}) + AX_W'({cfg.player_y, 7'b0}));
      cell_x = cell_of(ax_ff);
      cell_y = cell_of(ay_ff);
      wall   = cell_x[4] || cell_y[4] || cfg.map[{cell_y[3:0], cell_x[3:0]}];
      at_max = (n_ff == N_W'(MAX_STEPS));
      if (32'(n_ff) >= rcm_pkg::ROW_SCALE) begin
         row_num = DIVD_W'(SCREEN_HEIGHT * (32'(n_ff) - rcm_pkg::ROW_SCALE));
      end else begin
         row_num = '0;
      end
      floor_val = H_W'(SCREEN_HEIGHT) - ceil_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         col_ff <= column;
      end
      if (cmd.angle_mul) begin
         prod_ff <= DIVD_W'(col_ff) * DIVD_W'(cfg.fov);
      end else if (cmd.row_mul) begin
         prod_ff <= row_num;
      end
      if (cmd.angle_div) begin
         span_ff <= rcm_pkg::ANGLE_W'(span_prod >> RCP_SH);
      end
      if (cmd.angle_load) begin
         angle_ff <= cfg.player_angle - (cfg.fov >> 1) + span_ff;
      end
      if (cmd.sin_rd) begin
         rom_ff <= rcm_pkg::SIN_ROM[rom_index(angle_ff)];
         neg_ff <= angle_ff[11];
      end else if (cmd.cos_rd) begin
         s_ff   <= trig_val;
         rom_ff <= rcm_pkg::SIN_ROM[rom_index(cos_angle)];
         neg_ff <= cos_angle[11];
      end
      if (cmd.setup) begin
         c_ff  <= trig_val;
         ax_ff <= base_x + AX_W'(s_ff);
         ay_ff <= base_y + AX_W'(trig_val);
         n_ff  <= N_W'(1);
      end else if (cmd.march_step) begin
         if (wall || at_max) begin
            hit_ff <= wall;
         end else begin
            ax_ff <= ax_ff + AX_W'(s_ff);
            ay_ff <= ay_ff + AX_W'(c_ff);
            n_ff  <= n_ff + 1'b1;
         end
      end
      if (cmd.ceil_load) begin
         if (quot > DIVD_W'(SCREEN_HEIGHT)) begin
            ceil_ff <= H_W'(SCREEN_HEIGHT);
         end else begin
            ceil_ff <= H_W'(quot);
         end
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {6'b0, rcm_pkg::OUT_W'(floor_val), rcm_pkg::OUT_W'(ceil_ff),
                         hit_ff, rcm_pkg::OUT_W'(n_ff), col_ff};
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.div_done  = div_done;
   assign sts.march_end = wall || at_max;
   assign sts.rsp_hold  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      cmd.march_step |-> (n_ff != '0) && (32'(n_ff) <= MAX_STEPS))
      else $error("march step count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result overwritten while held");

   a_rows_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.ceil_load |=> (32'(ceil_ff) <= SCREEN_HEIGHT))
      else $error("ceiling row beyond screen");

endmodule

### hw/rtl/rcm_ctrl.sv
module rcm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rcm_pkg::sts_type sts,
   output rcm_pkg::cmd_type cmd
);

   rcm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcm_pkg::ST_IDLE: begin
            if (req_valid) state_in = rcm_pkg::ST_ANG_MUL;
         end
         rcm_pkg::ST_ANG_MUL:  state_in = rcm_pkg::ST_ANG_GO;
         rcm_pkg::ST_ANG_GO:   state_in = rcm_pkg::ST_ANG_WAIT;
         rcm_pkg::ST_ANG_WAIT: state_in = rcm_pkg::ST_SIN;
         rcm_pkg::ST_SIN:      state_in = rcm_pkg::ST_COS;
         rcm_pkg::ST_COS:      state_in = rcm_pkg::ST_SETUP;
         rcm_pkg::ST_SETUP:    state_in = rcm_pkg::ST_MARCH;
         rcm_pkg::ST_MARCH: begin
            if (sts.march_end) state_in = rcm_pkg::ST_ROW_MUL;
         end
         rcm_pkg::ST_ROW_MUL:  state_in = rcm_pkg::ST_ROW_GO;
         rcm_pkg::ST_ROW_GO:   state_in = rcm_pkg::ST_ROW_WAIT;
         rcm_pkg::ST_ROW_WAIT: begin
            if (sts.div_done) state_in = rcm_pkg::ST_DONE;
         end
         rcm_pkg::ST_DONE: begin
            if (!sts.rsp_hold) state_in = rcm_pkg::ST_IDLE;
         end
         default: state_in = rcm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rcm_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         rcm_pkg::ST_ANG_MUL:  cmd.angle_mul = 1'b1;
         rcm_pkg::ST_ANG_GO:   cmd.angle_div = 1'b1;
         rcm_pkg::ST_ANG_WAIT: cmd.angle_load = 1'b1;
         rcm_pkg::ST_SIN:      cmd.sin_rd = 1'b1;
         rcm_pkg::ST_COS:      cmd.cos_rd = 1'b1;
         rcm_pkg::ST_SETUP:    cmd.setup = 1'b1;
         rcm_pkg::ST_MARCH:    cmd.march_step = 1'b1;
         rcm_pkg::ST_ROW_MUL:  cmd.row_mul = 1'b1;
         rcm_pkg::ST_ROW_GO:   cmd.div_start = 1'b1;
         rcm_pkg::ST_ROW_WAIT: cmd.ceil_load = sts.div_done;
         rcm_pkg::ST_DONE:     cmd.out_load = !sts.rsp_hold;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/raycast_column_march.sv
// Casts one ray per requested screen column over a 16 x 16 wall map and returns
// the step count, a hit flag and the ceiling and floor rows of the wall slice.
// The march takes 1..MAX_STEPS steps, one map lookup per cycle, and the ceiling
// row comes from a shift-subtract divider (21 bits wide at default parameters).
// A new result is not loaded while the previous one is still held at the output.
// One request is in flight at a time; the next one is taken as soon as the result
// sits in the output register. Map and player registers must be written through
// the csr port only while no request is in progress; the block itself does not
// enforce this.
module raycast_column_march #(
   parameter int SCREEN_WIDTH  = 360,
   parameter int SCREEN_HEIGHT = 228,
   parameter int MAX_STEPS     = 160
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // [8:0] column
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [8:0] column_out, [16:9] step_count, [17] hit_wall, [25:18] ceiling_row,
   // [33:26] floor_row
   output logic [rcm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rcm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rcm_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [rcm_pkg::CSR_DATA_W-1:0] map0_ff, map1_ff, map2_ff, map3_ff;
   logic [rcm_pkg::ANGLE_W-1:0]    px_ff, py_ff, pa_ff, fov_ff;
   logic                           csr_write;
   rcm_pkg::cfg_type               cfg;
   rcm_pkg::cmd_type               cmd;
   rcm_pkg::sts_type               sts;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         map0_ff <= 64'h8001_8001_8001_FFFF;
         map1_ff <= 64'h8001_8001_8001_8001;
         map2_ff <= 64'h8001_8001_8001_8001;
         map3_ff <= 64'hFFFF_8001_8001_8001;
         px_ff   <= 12'd2048;
         py_ff   <= 12'd2048;
         pa_ff   <= 12'd512;
         fov_ff  <= 12'd512;
      end else if (csr_write) begin
         unique case (csr_index)
            rcm_pkg::REG_MAP_0:    map0_ff <= csr_data;
            rcm_pkg::REG_MAP_1:    map1_ff <= csr_data;
            rcm_pkg::REG_MAP_2:    map2_ff <= csr_data;
            rcm_pkg::REG_MAP_3:    map3_ff <= csr_data;
            rcm_pkg::REG_PLAYER_X: px_ff   <= csr_data[rcm_pkg::ANGLE_W-1:0];
            rcm_pkg::REG_PLAYER_Y: py_ff   <= csr_data[rcm_pkg::ANGLE_W-1:0];
            rcm_pkg::REG_PLAYER_A: pa_ff   <= csr_data[rcm_pkg::ANGLE_W-1:0];
            rcm_pkg::REG_FOV:      fov_ff  <= csr_data[rcm_pkg::ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.map          = {map3_ff, map2_ff, map1_ff, map0_ff};
   assign cfg.player_x     = px_ff;
   assign cfg.player_y     = py_ff;
   assign cfg.player_angle = pa_ff;
   assign cfg.fov          = fov_ff;

   rcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcm_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .MAX_STEPS     (MAX_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .cfg       (cfg),
      .column    (req_tdata[rcm_pkg::COLUMN_W-1:0]),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata)
   );

endmodule

### tb/tb_raycast_column_march.sv
module tb_raycast_column_march;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCR_W = 360;
   localparam int SCR_H = 228;
   localparam int STEPS = 160;
   localparam int IDX_W = rcm_pkg::CSR_INDEX_W;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [7:0] floor_row;
      logic [7:0] ceiling_row;
      logic       hit_wall;
      logic [7:0] step_count;
      logic [8:0] column_out;
   } slice_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rcm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rcm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rcm_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic [63:0] walls [4];
   logic [11:0] pos_x, pos_y, view_angle, view_fov;
   slice_type expected_slices [$];
   int errors = 0;
   longint cycles = 0;
   int burst_left = 0;

   raycast_column_march u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stall pattern: long ready stretches, then phases of light to heavy random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case ((cycles / 256) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   function automatic longint qsin(int q);
      longint x, x2, term, sum, r;
      x = longint'(q) * 1647099;
      x2 = (x * x) >>> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 6; k++) begin
         term = (term * x2) >>> 30;
         term = term / ((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      r = (sum + 32768) >>> 16;
      if (r > 16384) r = 16384;
      return r;
   endfunction

   function automatic longint turn_sin(logic [11:0] a);
      longint v;
      v = a[10] ? qsin(1024 - int'(a[9:0])) : qsin(int'(a[9:0]));
      return a[11] ? -v : v;
   endfunction

   function automatic bit cell_blocked(longint cx, longint cy);
      logic [63:0] row_bits;
      if (cx < 0 || cx > 15 || cy < 0 || cy > 15) return 1'b1;
      row_bits = walls[cy / 4];
      return row_bits[(cy % 4) * 16 + cx];
   endfunction

   function automatic slice_type cast_column(logic [8:0] col);
      slice_type s;
      logic [11:0] ang;
      longint sn, cs, bx, by, n, ceil_r;
      bit hit;
      ang = view_angle - (view_fov >> 1) + 12'((32'(col) * 32'(view_fov)) / SCR_W);
      sn = turn_sin(ang);
      cs = turn_sin(ang + 12'd1024);
      bx = longint'(pos_x) * 640;
      by = longint'(pos_y) * 640;
      n = 0;
      hit = 0;
      while (n < STEPS) begin
         n++;
         if (cell_blocked((bx + sn * n) / 163840, (by + cs * n) / 163840)) begin
            hit = 1;
            break;
         end
      end
      ceil_r = (SCR_H * n - 20 * SCR_H) / (2 * n);
      if (ceil_r < 0) ceil_r = 0;
      if (ceil_r > SCR_H) ceil_r = SCR_H;
      s.column_out = col;
      s.step_count = 8'(n);
      s.hit_wall = hit;
      s.ceiling_row = 8'(ceil_r);
      s.floor_row = 8'(SCR_H - ceil_r);
      return s;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d want %0d", what, got, want);
   endtask

   always @(posedge clock) begin
      slice_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[33:0];
         if (expected_slices.size() == 0) begin
            report_mismatch("unexpected response col", got.column_out, -1);
         end else begin
            want = expected_slices.pop_front();
            if (got.column_out !== want.column_out)
               report_mismatch("column_out", got.column_out, want.column_out);
            if (got.step_count !== want.step_count)
               report_mismatch("step_count", got.step_count, want.step_count);
            if (got.hit_wall !== want.hit_wall)
               report_mismatch("hit_wall", got.hit_wall, want.hit_wall);
            if (got.ceiling_row !== want.ceiling_row)
               report_mismatch("ceiling_row", got.ceiling_row, want.ceiling_row);
            if (got.floor_row !== want.floor_row)
               report_mismatch("floor_row", got.floor_row, want.floor_row);
         end
      end
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         rcm_pkg::REG_MAP_0: walls[0] = val;
         rcm_pkg::REG_MAP_1: walls[1] = val;
         rcm_pkg::REG_MAP_2: walls[2] = val;
         rcm_pkg::REG_MAP_3: walls[3] = val;
         rcm_pkg::REG_PLAYER_X: pos_x = val[11:0];
         rcm_pkg::REG_PLAYER_Y: pos_y = val[11:0];
         rcm_pkg::REG_PLAYER_A: view_angle = val[11:0];
         rcm_pkg::REG_FOV: view_fov = val[11:0];
         default: ;
      endcase
   endtask

   // valid stays high after a request until the next one, a gap or a drain
   task automatic send_column(logic [8:0] col, bit pace);
      int gap;
      if (pace) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 8);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'(0), col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_slices.push_back(cast_column(col));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_slices.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_view(logic [11:0] x, logic [11:0] y, logic [11:0] a, logic [11:0] f);
      write_reg(rcm_pkg::REG_PLAYER_X, 64'(x));
      write_reg(rcm_pkg::REG_PLAYER_Y, 64'(y));
      write_reg(rcm_pkg::REG_PLAYER_A, 64'(a));
      write_reg(rcm_pkg::REG_FOV, 64'(f));
   endtask

   task automatic test_reset_room();
      foreach (walls[i]) walls[i] = 64'h8001800180018001;
      walls[0] = 64'h800180018001FFFF;
      walls[3] = 64'hFFFF800180018001;
      pos_x = 2048; pos_y = 2048; view_angle = 512; view_fov = 512;
      send_column(0, 0);
      send_column(359, 0);
      send_column(180, 0);
      send_column(511, 0);
      drain();
   endtask

   task automatic test_directed_extremes();
      // open map: rays leave the map (outside cells count as walls)
      for (int i = 0; i < 4; i++) write_reg(IDX_W'(rcm_pkg::REG_MAP_0 + i), 64'h0);
      set_view(12'd0, 12'd0, 12'd0, 12'd0);
      send_column(0, 0);
      drain();
      set_view(12'hFFF, 12'hFFF, 12'hFFF, 12'd2048);
      send_column(0, 0); send_column(359, 0); send_column(511, 0);
      drain();
      // long ray inside an empty map reaching the step limit
      set_view(12'd16, 12'd16, 12'd512, 12'd4095);
      for (int c = 0; c < 8; c++) send_column(9'(c * 64), 0);
      drain();
      // solid map: hit at first step
      for (int i = 0; i < 4; i++) write_reg(IDX_W'(rcm_pkg::REG_MAP_0 + i), '1);
      set_view(12'd2048, 12'd2048, 12'd1024, 12'd512);
      send_column(100, 0); send_column(256, 0);
      drain();
      // unknown register index must be ignored
      write_reg(8'd200, 64'h0);
      send_column(1, 0);
      drain();
   endtask

   task automatic test_random_views();
      logic [63:0] m;
      for (int ph = 0; ph < 28; ph++) begin
         for (int i = 0; i < 4; i++) begin
            m = {$urandom, $urandom};
            if (ph % 3 == 0) m = m & {$urandom, $urandom} & {$urandom, $urandom};
            if (ph % 7 == 1) m = 64'h0;
            write_reg(IDX_W'(rcm_pkg::REG_MAP_0 + i), m);
         end
         if (ph % 5 == 0)
            set_view(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
         else
            set_view(12'($urandom_range(256, 3839)), 12'($urandom_range(256, 3839)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 2048)));
         for (int k = 0; k < 50; k++)
            send_column(($urandom_range(0, 15) == 0) ? 9'($urandom_range(0, 511))
                        : 9'($urandom_range(0, 359)), 1);
         drain();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_room();
      test_directed_extremes();
      test_random_views();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
